>>> design/aarm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aarm_pkg;

    // Front end: squared length, then digit-by-digit square root and divides
    localparam int SQRT_STEPS     = 32;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;
    localparam int DIV_STEPS      = 16;
    localparam int DIV_PER_STAGE  = 2;
    localparam int DIV_STAGES     = DIV_STEPS / DIV_PER_STAGE;
    localparam int NORM_LAT       = 1 + SQRT_STAGES + 1 + DIV_STAGES;

    // Trig path: x, x^2, Horner steps of three stages, sine product, quadrant
    localparam int HORNER_STEPS   = 5;
    localparam int SC_LAT         = 2 + 3 * HORNER_STEPS + 2;
    localparam int SC_PAD         = NORM_LAT - SC_LAT;

    localparam int MAT_LAT        = 4;
    localparam int NUM_ENTRIES    = 9;

    localparam logic [32:0] X_SCALE   = 33'd6746518852;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [32:0] TWO_POW32 = 33'h1_0000_0000;

    localparam logic signed [15:0] Q14_ONE  = 16'sd16384;
    localparam logic signed [15:0] Q14_MONE = -16'sd16384;

    // Series divisors; the sine series has one step fewer than the cosine
    localparam logic [HORNER_STEPS-1:0] SIN_ACT = 5'b01111;
    localparam logic [6:0]  SIN_DIV [HORNER_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6, 7'd1};
    localparam logic [6:0]  COS_DIV [HORNER_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
        32'(TWO_POW32 / 33'd72), 32'(TWO_POW32 / 33'd42), 32'(TWO_POW32 / 33'd20),
        32'(TWO_POW32 / 33'd6), 32'd0};
    localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
        32'(TWO_POW32 / 33'd90), 32'(TWO_POW32 / 33'd56), 32'(TWO_POW32 / 33'd30),
        32'(TWO_POW32 / 33'd12), 32'(TWO_POW32 / 33'd2)};

    typedef struct packed {
        logic             valid;
        logic             degen;
        logic [2:0][16:0] n;      // unit axis, Q1.15, two's complement
    } t_norm;

    typedef struct packed {
        logic signed [31:0] s;    // Q.30
        logic signed [31:0] c;    // Q.30
        logic signed [32:0] k;    // 1 - c, Q.30
    } t_trig;

    typedef struct packed {
        logic [NUM_ENTRIES-1:0][15:0] r;
        logic                         degen;
    } t_res;

endpackage

`default_nettype wire

>>> design/aarm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aarm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [15:0] angle;

    modport source (output valid, output axis_x, output axis_y, output axis_z,
                    output angle, input ready);
    modport sink   (input valid, input axis_x, input axis_y, input axis_z,
                    input angle, output ready);
endinterface

`default_nettype wire

>>> design/aarm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface aarm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic               degenerate;

    modport source (output valid, output r00, output r01, output r02, output r10,
                    output r11, output r12, output r20, output r21, output r22,
                    output degenerate, input ready);
    modport sink   (input valid, input r00, input r01, input r02, input r10,
                    input r11, input r12, input r20, input r21, input r22,
                    input degenerate, output ready);
endinterface

`default_nettype wire

>>> design/aarm_norm.sv
`timescale 1ns / 1ps
`default_nettype none

module aarm_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    output aarm_pkg::t_norm    o_norm
);
    import aarm_pkg::*;

    typedef struct packed {
        logic             degen;
        logic [2:0][15:0] mag;
        logic [2:0]       neg;
    } t_side;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [31:0] pend;
    } t_sqrt;

    typedef struct packed {
        logic [2:0][31:0] rem;
        logic [2:0][15:0] lo;
        logic [2:0][15:0] quot;
        logic [31:0]      q;
    } t_div;

    function automatic t_sqrt sqrt_step(input t_sqrt a);
        logic [35:0] rem2;
        logic [35:0] trial;
        t_sqrt       b;
        rem2   = {a.rem, a.pend[31:30]};
        trial  = {2'b00, a.root, 2'b01};
        b.pend = {a.pend[29:0], 2'b00};
        if (rem2 >= trial) begin
            b.rem  = 34'(rem2 - trial);
            b.root = {a.root[30:0], 1'b1};
        end else begin
            b.rem  = rem2[33:0];
            b.root = {a.root[30:0], 1'b0};
        end
        return b;
    endfunction

    function automatic t_div div_step(input t_div a);
        logic [32:0] rem2;
        t_div        b;
        b = a;
        for (int l = 0; l < 3; l++) begin
            rem2      = {a.rem[l], a.lo[l][15]};
            b.lo[l]   = {a.lo[l][14:0], 1'b0};
            if (rem2 >= {1'b0, a.q}) begin
                b.rem[l]  = 32'(rem2 - {1'b0, a.q});
                b.quot[l] = {a.quot[l][14:0], 1'b1};
            end else begin
                b.rem[l]  = rem2[31:0];
                b.quot[l] = {a.quot[l][14:0], 1'b0};
            end
        end
        return b;
    endfunction

    logic [NORM_LAT-1:0] r_vld;
    logic [31:0]         r_len2;
    t_side               r_side0;
    t_sqrt               r_sq      [SQRT_STAGES];
    t_side               r_sq_side [SQRT_STAGES];
    t_div                r_dv      [DIV_STAGES+1];
    t_side               r_dv_side [DIV_STAGES+1];

    t_side               n_side0;
    logic [31:0]         n_len2;
    t_sqrt               n_sq      [SQRT_STAGES];
    t_div                n_dv      [DIV_STAGES+1];

    // Magnitudes and signs; |-32768| lands on 32768 in 16 unsigned bits
    always_comb begin
        logic signed [15:0] a [3];
        logic [31:0]        sq [3];
        a[0] = i_axis_x;
        a[1] = i_axis_y;
        a[2] = i_axis_z;
        for (int l = 0; l < 3; l++) begin
            n_side0.neg[l] = a[l][15];
            n_side0.mag[l] = a[l][15] ? 16'(-a[l]) : a[l];
            sq[l]          = 32'(a[l] * a[l]);
        end
        n_len2        = sq[0] + sq[1] + sq[2];
        n_side0.degen = (i_axis_x == '0) && (i_axis_y == '0) && (i_axis_z == '0);
    end

    // Two root bits per stage; radicand is the squared length shifted by 32
    always_comb begin
        t_sqrt w_in [SQRT_STAGES];
        w_in[0] = '{rem: '0, root: '0, pend: r_len2};
        for (int g = 1; g < SQRT_STAGES; g++) begin
            w_in[g] = r_sq[g-1];
        end
        for (int g = 0; g < SQRT_STAGES; g++) begin
            n_sq[g] = w_in[g];
            for (int j = 0; j < SQRT_PER_STAGE; j++) begin
                n_sq[g] = sqrt_step(n_sq[g]);
            end
        end
    end

    // Rounded quotient |a| * 2^31 / q, two quotient bits per stage
    always_comb begin
        logic [46:0] num;
        n_dv[0].q = r_sq[SQRT_STAGES-1].root;
        for (int l = 0; l < 3; l++) begin
            num = {r_sq_side[SQRT_STAGES-1].mag[l], 31'b0}
                + {16'b0, r_sq[SQRT_STAGES-1].root[31:1]};
            n_dv[0].rem[l]  = {1'b0, num[46:16]};
            n_dv[0].lo[l]   = num[15:0];
            n_dv[0].quot[l] = '0;
        end
        for (int g = 1; g <= DIV_STAGES; g++) begin
            n_dv[g] = r_dv[g-1];
            for (int j = 0; j < DIV_PER_STAGE; j++) begin
                n_dv[g] = div_step(n_dv[g]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NORM_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len2       <= n_len2;
            r_side0      <= n_side0;
            r_sq_side[0] <= r_side0;
            for (int g = 0; g < SQRT_STAGES; g++) begin
                r_sq[g] <= n_sq[g];
            end
            for (int g = 1; g < SQRT_STAGES; g++) begin
                r_sq_side[g] <= r_sq_side[g-1];
            end
            r_dv_side[0] <= r_sq_side[SQRT_STAGES-1];
            for (int g = 0; g <= DIV_STAGES; g++) begin
                r_dv[g] <= n_dv[g];
            end
            for (int g = 1; g <= DIV_STAGES; g++) begin
                r_dv_side[g] <= r_dv_side[g-1];
            end
        end
    end

    // Clamp to one and restore the sign
    always_comb begin
        logic [15:0] qv;
        logic [16:0] m;
        o_norm.valid = r_vld[NORM_LAT-1];
        o_norm.degen = r_dv_side[DIV_STAGES].degen;
        for (int l = 0; l < 3; l++) begin
            qv = r_dv[DIV_STAGES].quot[l];
            m  = (qv > 16'd32768) ? 17'd32768 : {1'b0, qv};
            o_norm.n[l] = r_dv_side[DIV_STAGES].neg[l] ? 17'(-m) : m;
        end
    end

endmodule

`default_nettype wire

>>> design/aarm_sincos.sv
`timescale 1ns / 1ps
`default_nettype none

module aarm_sincos (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [15:0]     i_angle,
    output aarm_pkg::t_trig o_trig
);
    import aarm_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [1:0]  quad;
        logic        swap;
        logic [29:0] x;
        logic [29:0] x2;
        logic [30:0] ts;
        logic [30:0] tc;
        logic [29:0] ps;
        logic [29:0] pc;
        logic [29:0] qs;
        logic [29:0] qc;
    } t_sc;

    typedef struct packed {
        logic [1:0]  quad;
        logic        swap;
        logic [30:0] sv;
        logic [30:0] cv;
    } t_fin;

    logic [1:0]  r_quad0;
    logic        r_swap0;
    logic [29:0] r_x0;
    t_sc         r_s1;
    t_sc         r_a [HORNER_STEPS];
    t_sc         r_b [HORNER_STEPS];
    t_sc         r_c [HORNER_STEPS];
    t_fin        r_fin;
    t_trig       r_pad [SC_PAD+1];

    logic [29:0] n_x0;
    logic        n_swap0;
    t_sc         n_s1;
    t_sc         n_a [HORNER_STEPS];
    t_sc         n_b [HORNER_STEPS];
    t_sc         n_c [HORNER_STEPS];
    t_fin        n_fin;
    t_trig       n_trig;

    // Fold to the first octant, scale turns to radians in Q.30
    always_comb begin
        logic [13:0] r;
        logic [13:0] rf;
        logic [46:0] prod;
        r       = i_angle[13:0];
        n_swap0 = r > 14'd8192;
        rf      = n_swap0 ? 14'(15'd16384 - {1'b0, r}) : r;
        prod    = 47'(rf * X_SCALE) + 47'h8000;
        n_x0    = prod[45:16];
    end

    always_comb begin
        logic [60:0] sq;
        sq         = 61'(r_x0 * r_x0) + 61'h2000_0000;
        n_s1       = '0;
        n_s1.quad  = r_quad0;
        n_s1.swap  = r_swap0;
        n_s1.x     = r_x0;
        n_s1.x2    = sq[59:30];
        n_s1.ts    = ONE_Q30;
        n_s1.tc    = ONE_Q30;
    end

    // Horner step: product, reciprocal multiply, then a one-step correction
    always_comb begin
        t_sc         src [HORNER_STEPS];
        logic [60:0] pm;
        logic [61:0] rm;
        logic [36:0] qd;
        logic [36:0] diff;
        src[0] = r_s1;
        for (int h = 1; h < HORNER_STEPS; h++) begin
            src[h] = r_c[h-1];
        end
        for (int h = 0; h < HORNER_STEPS; h++) begin
            n_a[h] = src[h];
            pm = 61'(src[h].x2 * src[h].tc);
            n_a[h].pc = pm[59:30];
            if (SIN_ACT[h]) begin
                pm = 61'(src[h].x2 * src[h].ts);
                n_a[h].ps = pm[59:30];
            end

            n_b[h] = r_a[h];
            rm = 62'(r_a[h].pc * COS_RCP[h]);
            n_b[h].qc = rm[61:32];
            if (SIN_ACT[h]) begin
                rm = 62'(r_a[h].ps * SIN_RCP[h]);
                n_b[h].qs = rm[61:32];
            end

            n_c[h] = r_b[h];
            qd   = 37'(r_b[h].qc * COS_DIV[h]);
            diff = {7'b0, r_b[h].pc} - qd;
            n_c[h].tc = ONE_Q30 - {1'b0, 30'(r_b[h].qc + 30'(diff[7:0] >= {1'b0, COS_DIV[h]}))};
            if (SIN_ACT[h]) begin
                qd   = 37'(r_b[h].qs * SIN_DIV[h]);
                diff = {7'b0, r_b[h].ps} - qd;
                n_c[h].ts = ONE_Q30
                          - {1'b0, 30'(r_b[h].qs + 30'(diff[7:0] >= {1'b0, SIN_DIV[h]}))};
            end
        end
    end

    always_comb begin
        logic [60:0] pm;
        pm         = 61'(r_c[HORNER_STEPS-1].x * r_c[HORNER_STEPS-1].ts);
        n_fin.quad = r_c[HORNER_STEPS-1].quad;
        n_fin.swap = r_c[HORNER_STEPS-1].swap;
        n_fin.sv   = pm[60:30];
        n_fin.cv   = r_c[HORNER_STEPS-1].tc;
    end

    // Undo the octant fold, apply quadrant signs
    always_comb begin
        logic signed [31:0] sr;
        logic signed [31:0] cr;
        sr = $signed({1'b0, r_fin.swap ? r_fin.cv : r_fin.sv});
        cr = $signed({1'b0, r_fin.swap ? r_fin.sv : r_fin.cv});
        unique case (r_fin.quad)
            QUAD_0: begin n_trig.s = sr;  n_trig.c = cr;  end
            QUAD_1: begin n_trig.s = cr;  n_trig.c = -sr; end
            QUAD_2: begin n_trig.s = -sr; n_trig.c = -cr; end
            QUAD_3: begin n_trig.s = -cr; n_trig.c = sr;  end
        endcase
        n_trig.k = $signed({2'b00, ONE_Q30}) - 33'(n_trig.c);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad0  <= i_angle[15:14];
            r_swap0  <= n_swap0;
            r_x0     <= n_x0;
            r_s1     <= n_s1;
            for (int h = 0; h < HORNER_STEPS; h++) begin
                r_a[h] <= n_a[h];
                r_b[h] <= n_b[h];
                r_c[h] <= n_c[h];
            end
            r_fin    <= n_fin;
            r_pad[0] <= n_trig;
            for (int g = 1; g <= SC_PAD; g++) begin
                r_pad[g] <= r_pad[g-1];
            end
        end
    end

    assign o_trig = r_pad[SC_PAD];

endmodule

`default_nettype wire

>>> design/aarm_matrix.sv
`timescale 1ns / 1ps
`default_nettype none

module aarm_matrix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  aarm_pkg::t_norm i_norm,
    input  aarm_pkg::t_trig i_trig,
    output logic            o_valid,
    output aarm_pkg::t_res  o_res
);
    import aarm_pkg::*;

    localparam int XX = 0;
    localparam int YY = 1;
    localparam int ZZ = 2;
    localparam int XY = 3;
    localparam int YZ = 4;
    localparam int ZX = 5;

    // Half away from zero at bit 46, then saturate to plus or minus one
    function automatic logic [15:0] to_q14(input logic signed [63:0] v);
        logic signed [63:0] h;
        logic signed [63:0] rs;
        logic [15:0]        res;
        h  = v[63] ? 64'sh1FFF_FFFF_FFFF : 64'sh2000_0000_0000;
        rs = (v + h) >>> 46;
        if (rs > Q14_ONE) begin
            res = Q14_ONE;
        end else if (rs < Q14_MONE) begin
            res = Q14_MONE;
        end else begin
            res = rs[15:0];
        end
        return res;
    endfunction

    logic [MAT_LAT-1:0] r_vld;
    logic [MAT_LAT-2:0] r_degen;
    logic signed [33:0] r_p  [6];
    logic signed [48:0] r_s1 [3];
    logic signed [48:0] r_s2 [3];
    logic signed [31:0] r_c1;
    logic signed [31:0] r_c2;
    logic signed [32:0] r_k1;
    logic signed [63:0] r_kp [6];
    logic signed [63:0] r_e  [NUM_ENTRIES];
    t_res               r_res;

    logic signed [16:0] w_n [3];
    logic signed [63:0] n_e [NUM_ENTRIES];
    t_res               n_res;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_n[l] = $signed(i_norm.n[l]);
        end
    end

    always_comb begin
        logic signed [63:0] c60;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic signed [63:0] zs;
        c60 = {{2{r_c2[31]}}, r_c2, 30'b0};
        xs  = {r_s2[0], 15'b0};
        ys  = {r_s2[1], 15'b0};
        zs  = {r_s2[2], 15'b0};
        n_e[0] = r_kp[XX] + c60;
        n_e[1] = r_kp[XY] + zs;
        n_e[2] = r_kp[ZX] - ys;
        n_e[3] = r_kp[XY] - zs;
        n_e[4] = r_kp[YY] + c60;
        n_e[5] = r_kp[YZ] + xs;
        n_e[6] = r_kp[ZX] + ys;
        n_e[7] = r_kp[YZ] - xs;
        n_e[8] = r_kp[ZZ] + c60;
    end

    // Zero axis: drop the arithmetic, give the identity
    always_comb begin
        n_res.degen = r_degen[MAT_LAT-2];
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (r_degen[MAT_LAT-2]) begin
                n_res.r[i] = (i == 0 || i == 4 || i == 8) ? Q14_ONE : '0;
            end else begin
                n_res.r[i] = to_q14(r_e[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[MAT_LAT-2:0], i_norm.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_degen  <= {r_degen[MAT_LAT-3:0], i_norm.degen};
            r_p[XX]  <= w_n[0] * w_n[0];
            r_p[YY]  <= w_n[1] * w_n[1];
            r_p[ZZ]  <= w_n[2] * w_n[2];
            r_p[XY]  <= w_n[0] * w_n[1];
            r_p[YZ]  <= w_n[1] * w_n[2];
            r_p[ZX]  <= w_n[2] * w_n[0];
            for (int l = 0; l < 3; l++) begin
                r_s1[l] <= w_n[l] * i_trig.s;
                r_s2[l] <= r_s1[l];
            end
            r_c1 <= i_trig.c;
            r_k1 <= i_trig.k;
            r_c2 <= r_c1;
            for (int i = 0; i < 6; i++) begin
                r_kp[i] <= 64'(r_p[i] * r_k1);
            end
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_e[i] <= n_e[i];
            end
            r_res <= n_res;
        end
    end

    assign o_valid = r_vld[MAT_LAT-1];
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> design/axis_angle_rotation_matrix.sv
// The path from an accepted input beat to its result beat on o_out is
//   set by the 16-stage square root (two root bits a stage), the divide and the matrix stages.
// Throughput: one beat per cycle while the skid is empty; the trig path runs alongside the normalizer.
// A stalled output holds one result and parks one more in a skid register.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module axis_angle_rotation_matrix (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aarm_in_if.sink   i_in,
    aarm_out_if.source o_out
);
    import aarm_pkg::*;

    logic  w_en;
    logic  w_pop;
    logic  w_push;
    t_norm w_norm;
    t_trig w_trig;
    logic  w_mat_valid;
    t_res  w_mat;

    logic  r_out_valid;
    logic  r_skid_valid;
    t_res  r_out;
    t_res  r_skid;

    // The whole pipeline advances as one; it stops only when the skid is full,
    // so ready never depends combinationally on the output side.
    assign w_en       = !r_skid_valid;
    assign i_in.ready = w_en;

    // Axis length, inverse square root by root and divide, Q1.15 unit axis
    aarm_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in.valid),
        .i_axis_x (i_in.axis_x),
        .i_axis_y (i_in.axis_y),
        .i_axis_z (i_in.axis_z),
        .o_norm   (w_norm)
    );

    // Sine, cosine and 1 - cosine, delayed to line up with the unit axis
    aarm_sincos u_sincos (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in.angle),
        .o_trig  (w_trig)
    );

    // Rodrigues products, exact Q.60 sums, rounding and saturation
    aarm_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_norm  (w_norm),
        .i_trig  (w_trig),
        .o_valid (w_mat_valid),
        .o_res   (w_mat)
    );

    assign w_pop  = r_out_valid && o_out.ready;
    assign w_push = w_en && w_mat_valid;

    // Output register plus skid: a beat leaving the pipeline goes to the output
    // register if that is free or draining, else it waits in the skid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out       <= w_mat;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_mat;
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.r00        = r_out.r[0];
    assign o_out.r01        = r_out.r[1];
    assign o_out.r02        = r_out.r[2];
    assign o_out.r10        = r_out.r[3];
    assign o_out.r11        = r_out.r[4];
    assign o_out.r12        = r_out.r[5];
    assign o_out.r20        = r_out.r[6];
    assign o_out.r21        = r_out.r[7];
    assign o_out.r22        = r_out.r[8];
    assign o_out.degenerate = r_out.degen;

endmodule

`default_nettype wire

>>> design/aarm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module aarm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_r00,
    input logic signed [15:0] i_r01,
    input logic signed [15:0] i_r02,
    input logic signed [15:0] i_r10,
    input logic signed [15:0] i_r11,
    input logic signed [15:0] i_r12,
    input logic signed [15:0] i_r20,
    input logic signed [15:0] i_r21,
    input logic signed [15:0] i_r22,
    input logic               i_degenerate
);

    function automatic logic in_unit(input logic signed [15:0] v);
        return (v >= -16'sd16384) && (v <= 16'sd16384);
    endfunction

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_r00, i_r01, i_r02, i_r10, i_r11, i_r12, i_r20, i_r21, i_r22,
                 i_degenerate}))
        else $error("result beat changed while stalled");

    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |->
        i_r00 == 16'sd16384 && i_r11 == 16'sd16384 && i_r22 == 16'sd16384 &&
        i_r01 == 0 && i_r02 == 0 && i_r10 == 0 && i_r12 == 0 && i_r20 == 0 && i_r21 == 0)
        else $error("degenerate beat is not the identity");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> in_unit(i_r00) && in_unit(i_r01) && in_unit(i_r02) &&
        in_unit(i_r10) && in_unit(i_r11) && in_unit(i_r12) &&
        in_unit(i_r20) && in_unit(i_r21) && in_unit(i_r22))
        else $error("matrix entry outside plus or minus one");

    // Input backpressure only comes from a held result
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_r00        (o_out.r00),
    .i_r01        (o_out.r01),
    .i_r02        (o_out.r02),
    .i_r10        (o_out.r10),
    .i_r11        (o_out.r11),
    .i_r12        (o_out.r12),
    .i_r20        (o_out.r20),
    .i_r21        (o_out.r21),
    .i_r22        (o_out.r22),
    .i_degenerate (o_out.degenerate)
);

`default_nettype wire
